@@ rtl/core/csr_pkg.sv @@
// ----------------------------------------------------------------------------
// csr_pkg
// shared constants and types for the segment reassembler
// ----------------------------------------------------------------------------
package csr_pkg;

   localparam int unsigned NumBuffersDefault  = 4;
   localparam int unsigned MaxSegmentsDefault = 32;
   localparam int unsigned SegmentBytes       = 7;
   localparam int unsigned ResultLimit        = 32;
   localparam logic [31:0] TimeoutReset       = 32'd20000;

   localparam int unsigned IdWidth    = 29;
   localparam int unsigned DataWidth  = 56;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned LenWidth   = 9;

   typedef enum logic [1:0] {
      SEG_SINGLE = 2'd0,
      SEG_BEGIN  = 2'd1,
      SEG_MIDDLE = 2'd2,
      SEG_END    = 2'd3
   } seg_type_type;

   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_FULL    = 2'd1,
      ST_NOMATCH = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_DECIDE,
      S_WRITE,
      S_READ,
      S_EMIT,
      S_STATUS
   } state_type;

   // request from controller to the byte store
   typedef struct packed {
      logic        wr_en;
      logic [6:0]  wr_mask;
      logic        rd_en;
   } mem_ctl_type;

endpackage

@@ rtl/core/csr_store.sv @@
// ----------------------------------------------------------------------------
// csr_store
// message byte memory, one 7-byte row per segment slot, byte write mask
// ----------------------------------------------------------------------------
module csr_store #(
   parameter int unsigned ADDR_W = 7
) (
   input  logic                          clock,
   input  csr_pkg::mem_ctl_type          ctl,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [csr_pkg::DataWidth-1:0] wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [csr_pkg::DataWidth-1:0] rd_data
);

   localparam int unsigned Depth = 1 << ADDR_W;

   logic [csr_pkg::DataWidth-1:0] mem [Depth];
   logic [csr_pkg::DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         for (int k = 0; k < 7; k++) begin
            if (ctl.wr_mask[k]) begin
               mem[wr_addr][8*k +: 8] <= wr_data[8*k +: 8];
            end
         end
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/can_segment_reassembler_core.sv @@
// ----------------------------------------------------------------------------
// can_segment_reassembler_core
// reassembles segmented can messages into per-id buffers and streams them
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   req_valid/req_stall frame_id seg_type seg_index byte_count
//                                   payload now
// rsp      out  rsp_valid/rsp_stall status msg_id chunk chunk_bytes last
// csr      in   csr_valid/csr_ready timeout_ticks write data
//
// one item at a time: a sweep over all NUM_BUFFERS entries for timeouts,
// a decide state, then a write or status state; an end segment then reads
// one memory row per chunk (a read state, then an emit state that waits on
// output stall); a single frame is taken and ignored without leaving idle
// synchronous reset clears buffer table and sets timeout to its default;
// message memory is not cleared, no clearing pass
// rsp is a single output register; req_stall is high whenever busy
// ----------------------------------------------------------------------------
module can_segment_reassembler_core #(
   parameter int unsigned NUM_BUFFERS  = csr_pkg::NumBuffersDefault,
   parameter int unsigned MAX_SEGMENTS = csr_pkg::MaxSegmentsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [28:0] req_frame_id,
   input  logic [1:0]  req_seg_type,
   input  logic [5:0]  req_seg_index,
   input  logic [2:0]  req_byte_count,
   input  logic [55:0] req_payload,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [28:0] rsp_msg_id,
   output logic [55:0] rsp_chunk,
   output logic [2:0]  rsp_chunk_bytes,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_timeout_ticks
);

   localparam int unsigned BufW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int unsigned SegW   = $clog2(MAX_SEGMENTS);
   localparam int unsigned AddrW  = BufW + SegW;
   localparam int unsigned BufCap = MAX_SEGMENTS * csr_pkg::SegmentBytes;
   localparam logic [csr_pkg::LenWidth-1:0] CapLen = csr_pkg::LenWidth'(BufCap);
   localparam logic [csr_pkg::LenWidth-1:0] SegLen =
      csr_pkg::LenWidth'(csr_pkg::SegmentBytes);

   // buffer table, small, kept in flops
   logic [28:0]                  id_ff    [NUM_BUFFERS];
   logic [csr_pkg::LenWidth-1:0] len_ff   [NUM_BUFFERS];
   logic [31:0]                  start_ff [NUM_BUFFERS];
   logic [31:0]                  timeout_ff;

   // latched item
   logic [28:0] fid_ff;
   logic [1:0]  ftype_ff;
   logic [5:0]  fseg_ff;
   logic [2:0]  fcnt_ff;
   logic [55:0] fdata_ff;
   logic [31:0] fnow_ff;

   csr_pkg::state_type state_ff, state_in;
   logic [BufW-1:0]                sweep_ff;
   logic [BufW-1:0]                buf_ff;
   logic [csr_pkg::LenWidth-1:0]   olen_ff;     // bytes left to stream
   logic [SegW-1:0]                rrow_ff;
   logic [1:0]                     stat_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [55:0] rsp_chunk_ff;
   logic [2:0]  rsp_bytes_ff;
   logic        rsp_last_ff;

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // lookup over the table, after sweep
   logic             hit, free_ok;
   logic [BufW-1:0]  hit_idx, free_idx;
   always_comb begin
      hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
      for (int b = NUM_BUFFERS - 1; b >= 0; b--) begin
         if (len_ff[b] != '0 && id_ff[b] == fid_ff) begin
            hit = 1'b1; hit_idx = BufW'(b);
         end
         if (len_ff[b] == '0) begin
            free_ok = 1'b1; free_idx = BufW'(b);
         end
      end
   end

   // memory control
   csr_pkg::mem_ctl_type      mctl;
   logic [AddrW-1:0]          waddr, raddr;
   logic [55:0]               rdata;
   logic [6:0]                cnt_mask;

   always_comb begin
      cnt_mask = '0;
      for (int k = 0; k < 7; k++) begin
         cnt_mask[k] = (3'(k) < fcnt_ff);
      end
   end

   assign waddr = {buf_ff, (ftype_ff == csr_pkg::SEG_BEGIN) ? SegW'(0) : fseg_ff[SegW-1:0]};
   assign raddr = {buf_ff, rrow_ff};

   always_comb begin
      mctl.wr_en   = (state_ff == csr_pkg::S_WRITE);
      mctl.wr_mask = (ftype_ff == csr_pkg::SEG_END) ? cnt_mask : 7'h7f;
      mctl.rd_en   = (state_ff == csr_pkg::S_READ);
   end

   csr_store #(.ADDR_W(AddrW)) u_store (
      .clock   (clock),
      .ctl     (mctl),
      .wr_addr (waddr),
      .wr_data (fdata_ff),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   logic seg_big;
   assign seg_big = ({1'b0, fseg_ff} >= 7'(MAX_SEGMENTS));

   // final chunk: message exhausted or the per-item result limit reached
   logic last_chunk;
   assign last_chunk = (olen_ff <= SegLen) ||
                       (6'(rrow_ff) == 6'(csr_pkg::ResultLimit - 1));

   // output register is loaded this cycle
   logic rsp_load;
   assign rsp_load = rsp_free &&
                     (state_ff == csr_pkg::S_EMIT || state_ff == csr_pkg::S_STATUS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csr_pkg::S_IDLE: begin
            if (req_valid && rsp_free && req_seg_type != csr_pkg::SEG_SINGLE) begin
               state_in = csr_pkg::S_SWEEP;
            end
         end
         csr_pkg::S_SWEEP: begin
            if (sweep_ff == BufW'(NUM_BUFFERS - 1)) state_in = csr_pkg::S_DECIDE;
         end
         csr_pkg::S_DECIDE: begin
            priority if (ftype_ff == csr_pkg::SEG_BEGIN) begin
               state_in = (hit || free_ok) ? csr_pkg::S_WRITE : csr_pkg::S_STATUS;
            end else if (!hit || seg_big) begin
               state_in = csr_pkg::S_STATUS;
            end else begin
               state_in = csr_pkg::S_WRITE;
            end
         end
         csr_pkg::S_WRITE: begin
            state_in = (ftype_ff == csr_pkg::SEG_END) ? csr_pkg::S_READ : csr_pkg::S_IDLE;
         end
         csr_pkg::S_READ:   state_in = csr_pkg::S_EMIT;
         csr_pkg::S_EMIT: begin
            if (rsp_free) begin
               state_in = last_chunk ? csr_pkg::S_IDLE : csr_pkg::S_READ;
            end
         end
         csr_pkg::S_STATUS: begin
            if (rsp_free) state_in = csr_pkg::S_IDLE;
         end
         default: state_in = csr_pkg::S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != csr_pkg::S_IDLE) || !rsp_free;
   assign csr_ready = (state_ff == csr_pkg::S_IDLE);

   logic [31:0] age;
   assign age = fnow_ff - start_ff[sweep_ff];

   logic [csr_pkg::LenWidth:0] sum_len;
   logic [csr_pkg::LenWidth-1:0] new_len;
   always_comb begin
      sum_len = {1'b0, len_ff[buf_ff]} +
         ((ftype_ff == csr_pkg::SEG_END) ? (csr_pkg::LenWidth+1)'(fcnt_ff)
                                         : (csr_pkg::LenWidth+1)'(SegLen));
      new_len = (sum_len > {1'b0, CapLen}) ? CapLen : sum_len[csr_pkg::LenWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= csr_pkg::TimeoutReset;
         sweep_ff     <= '0;
         for (int b = 0; b < NUM_BUFFERS; b++) begin
            id_ff[b] <= '0; len_ff[b] <= '0; start_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) timeout_ff <= csr_timeout_ticks;
         if (rsp_valid_ff && !rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            csr_pkg::S_IDLE: begin
               sweep_ff <= '0;
               if (req_valid && !req_stall) begin
                  fid_ff <= req_frame_id; ftype_ff <= req_seg_type;
                  fseg_ff <= req_seg_index; fcnt_ff <= req_byte_count;
                  fdata_ff <= req_payload; fnow_ff <= req_now;
               end
            end
            csr_pkg::S_SWEEP: begin
               // free a stale buffer, one entry per cycle
               if (len_ff[sweep_ff] != '0 && age > timeout_ff) begin
                  len_ff[sweep_ff] <= '0;
                  id_ff[sweep_ff]  <= '0;
               end
               sweep_ff <= sweep_ff + BufW'(1);
            end
            csr_pkg::S_DECIDE: begin
               buf_ff <= hit ? hit_idx : free_idx;
               priority if (ftype_ff == csr_pkg::SEG_BEGIN) stat_ff <= csr_pkg::ST_FULL;
               else if (!hit) stat_ff <= csr_pkg::ST_NOMATCH;
               else stat_ff <= csr_pkg::ST_RANGE;
            end
            csr_pkg::S_WRITE: begin
               start_ff[buf_ff] <= fnow_ff;
               rrow_ff <= '0;
               if (ftype_ff == csr_pkg::SEG_BEGIN) begin
                  len_ff[buf_ff] <= SegLen;
                  id_ff[buf_ff]  <= fid_ff;
               end else if (ftype_ff == csr_pkg::SEG_MIDDLE) begin
                  len_ff[buf_ff] <= new_len;
               end else begin
                  olen_ff        <= new_len;
                  len_ff[buf_ff] <= '0;   // freed, stream from memory
                  id_ff[buf_ff]  <= '0;
               end
            end
            csr_pkg::S_READ: ;
            csr_pkg::S_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= csr_pkg::ST_DATA;
                  rsp_last_ff   <= last_chunk;
                  rsp_bytes_ff  <= (olen_ff >= SegLen) ? 3'd7 : olen_ff[2:0];
                  for (int k = 0; k < 7; k++) begin
                     rsp_chunk_ff[8*k +: 8] <=
                        (csr_pkg::LenWidth'(k) < olen_ff) ? rdata[8*k +: 8] : 8'h00;
                  end
                  olen_ff <= (olen_ff > SegLen) ? olen_ff - SegLen : '0;
                  rrow_ff <= rrow_ff + SegW'(1);
               end
            end
            csr_pkg::S_STATUS: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= stat_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_bytes_ff  <= '0;
                  rsp_chunk_ff  <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_msg_id      = fid_ff;
   assign rsp_chunk       = rsp_chunk_ff;
   assign rsp_chunk_bytes = rsp_bytes_ff;
   assign rsp_last        = rsp_last_ff;

   // status results always close the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != csr_pkg::ST_DATA |-> rsp_last)
      else $error("status result without last");
   // no new item while a stream is being emitted
   assert property (@(posedge clock) disable iff (reset)
      state_ff == csr_pkg::S_EMIT |-> req_stall)
      else $error("item taken during stream");
   // a memory read always leads to emit
   assert property (@(posedge clock) disable iff (reset)
      state_ff == csr_pkg::S_READ |=> state_ff == csr_pkg::S_EMIT)
      else $error("read not followed by emit");

endmodule

@@ bench/tb_can_segment_reassembler_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_can_segment_reassembler_core
// self-checking bench: directed and random segmented can traffic is driven
// through the reassembler while a behavioral copy of the buffer table
// predicts every chunk and status item, across several timeout settings
// ----------------------------------------------------------------------------
module tb_can_segment_reassembler_core;

   localparam int NBUF      = 4;
   localparam int NSEG      = 32;
   localparam int CAP       = NSEG * csr_pkg::SegmentBytes;
   localparam int IDLE_MAX  = 20000;
   localparam int DRAIN_CYC = 120;

   typedef struct {
      logic [28:0]           frame_id;
      csr_pkg::seg_type_type seg_type;
      logic [5:0]            seg_index;
      logic [2:0]            byte_count;
      logic [55:0]           payload;
      logic [31:0]           now;
   } frame_type;

   typedef struct {
      csr_pkg::status_type status;
      logic [28:0]         msg_id;
      logic [55:0]         chunk;
      logic [2:0]          chunk_bytes;
      logic                last;
   } result_type;

   // buffer table plus a record of which byte slots were ever written
   typedef struct {
      logic [31:0] timeout;
      logic [28:0] ids    [NBUF];
      int          lens   [NBUF];
      logic [31:0] starts [NBUF];
      logic [7:0]  bytes  [NBUF][CAP];
      bit          written[NBUF][CAP];
   } reasm_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [28:0] req_frame_id;
   logic [1:0]  req_seg_type;
   logic [5:0]  req_seg_index;
   logic [2:0]  req_byte_count;
   logic [55:0] req_payload;
   logic [31:0] req_now;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [28:0] rsp_msg_id;
   logic [55:0] rsp_chunk;
   logic [2:0]  rsp_chunk_bytes;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_timeout_ticks;

   can_segment_reassembler_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_id     (req_frame_id),
      .req_seg_type     (req_seg_type),
      .req_seg_index    (req_seg_index),
      .req_byte_count   (req_byte_count),
      .req_payload      (req_payload),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_msg_id       (rsp_msg_id),
      .rsp_chunk        (rsp_chunk),
      .rsp_chunk_bytes  (rsp_chunk_bytes),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_timeout_ticks(csr_timeout_ticks)
   );

   frame_type  pending_frames[$];
   result_type expected_results[$];
   reasm_type  table_model;   // advanced on accepted items
   reasm_type  plan_model;    // advanced as items are queued, keeps stimulus legal

   bit          quiet;
   bit          req_fire;
   int          req_gap;
   int          stall_cnt;
   int          mismatches;
   int          idle_cycles;
   int          frames_sent;
   int          chunks_seen;
   int          status_seen;
   logic [31:0] tnow;
   logic [28:0] id_pool[6];

   // predicts the items one frame causes; flags a read of a never-written slot
   function automatic void apply_frame(inout reasm_type s, input frame_type f,
                                       inout result_type res[$], output bit unsafe);
      int          hit;
      int          pos;
      int          nchunks;
      int          nb;
      result_type  r;
      unsafe = 0;
      hit = -1;
      if (f.seg_type == csr_pkg::SEG_SINGLE) return;
      // timeout sweep
      for (int b = 0; b < NBUF; b++)
         if (s.lens[b] != 0 && (f.now - s.starts[b]) > s.timeout) begin
            s.lens[b] = 0;
            s.ids[b] = '0;
         end
      for (int b = NBUF - 1; b >= 0; b--)
         if (s.lens[b] != 0 && s.ids[b] == f.frame_id) hit = b;
      r.chunk = '0;
      r.chunk_bytes = '0;
      r.last = 1'b1;
      r.msg_id = f.frame_id;
      if (f.seg_type == csr_pkg::SEG_BEGIN) begin
         if (hit < 0)
            for (int b = NBUF - 1; b >= 0; b--)
               if (s.lens[b] == 0) hit = b;
         if (hit < 0) begin
            r.status = csr_pkg::ST_FULL;
            res.push_back(r);
            return;
         end
         for (int k = 0; k < csr_pkg::SegmentBytes; k++) begin
            s.bytes[hit][k] = f.payload[8*k +: 8];
            s.written[hit][k] = 1;
         end
         s.lens[hit] = csr_pkg::SegmentBytes;
         s.ids[hit] = f.frame_id;
         s.starts[hit] = f.now;
         return;
      end
      if (hit < 0) begin
         r.status = csr_pkg::ST_NOMATCH;
         res.push_back(r);
         return;
      end
      if (f.seg_index >= NSEG) begin
         r.status = csr_pkg::ST_RANGE;
         res.push_back(r);
         return;
      end
      s.starts[hit] = f.now;
      pos = f.seg_index * csr_pkg::SegmentBytes;
      nb = (f.seg_type == csr_pkg::SEG_MIDDLE) ? csr_pkg::SegmentBytes : int'(f.byte_count);
      for (int k = 0; k < nb; k++)
         if (pos + k < CAP) begin
            s.bytes[hit][pos + k] = f.payload[8*k +: 8];
            s.written[hit][pos + k] = 1;
         end
      s.lens[hit] = (s.lens[hit] + nb > CAP) ? CAP : s.lens[hit] + nb;
      if (f.seg_type == csr_pkg::SEG_MIDDLE) return;
      // end segment: stream the message out
      nchunks = (s.lens[hit] + csr_pkg::SegmentBytes - 1) / csr_pkg::SegmentBytes;
      for (int c = 0; c < nchunks; c++) begin
         nb = s.lens[hit] - c * csr_pkg::SegmentBytes;
         if (nb > csr_pkg::SegmentBytes) nb = csr_pkg::SegmentBytes;
         r.status = csr_pkg::ST_DATA;
         r.chunk = '0;
         for (int k = 0; k < nb; k++) begin
            if (!s.written[hit][c * csr_pkg::SegmentBytes + k]) unsafe = 1;
            r.chunk[8*k +: 8] = s.bytes[hit][c * csr_pkg::SegmentBytes + k];
         end
         r.chunk_bytes = nb[2:0];
         r.last = (c == nchunks - 1);
         res.push_back(r);
      end
      s.lens[hit] = 0;
      s.ids[hit] = '0;
   endfunction

   // queue a frame; an end that would stream unwritten bytes becomes a middle
   task automatic send(input frame_type f);
      reasm_type  trial;
      result_type dummy[$];
      bit         unsafe;
      trial = plan_model;
      apply_frame(trial, f, dummy, unsafe);
      if (unsafe) begin
         f.seg_type = csr_pkg::SEG_MIDDLE;
         trial = plan_model;
         dummy.delete();
         apply_frame(trial, f, dummy, unsafe);
      end
      plan_model = trial;
      pending_frames.push_back(f);
   endtask

   task automatic mk_send(input logic [28:0] id, input csr_pkg::seg_type_type st,
                          input logic [5:0] idx, input logic [2:0] cnt,
                          input logic [55:0] data, input logic [31:0] t);
      frame_type f;
      f.frame_id = id;
      f.seg_type = st;
      f.seg_index = idx;
      f.byte_count = cnt;
      f.payload = data;
      f.now = t;
      send(f);
   endtask

   function automatic logic [55:0] rand56();
      return 56'({$urandom, $urandom});
   endfunction

   // well-formed message of nseg segments, then an end with random byte count;
   // indices wrap so that very long messages revisit rows and saturate the length
   task automatic send_message(input logic [28:0] id, input int nseg, input int dt_max);
      tnow += $urandom_range(0, dt_max);
      mk_send(id, csr_pkg::SEG_BEGIN, 6'($urandom), 3'($urandom), rand56(), tnow);
      for (int s = 1; s < nseg; s++) begin
         tnow += $urandom_range(0, dt_max);
         mk_send(id, csr_pkg::SEG_MIDDLE, 6'(s % NSEG), 3'($urandom), rand56(), tnow);
      end
      tnow += $urandom_range(0, dt_max);
      mk_send(id, csr_pkg::SEG_END, 6'(nseg % NSEG), 3'($urandom), rand56(), tnow);
   endtask

   task automatic send_noise(input int dt_max);
      frame_type f;
      f.frame_id = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 5)]
                                                 : 29'($urandom);
      f.seg_type = csr_pkg::seg_type_type'($urandom_range(0, 3));
      f.seg_index = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
      f.byte_count = 3'($urandom);
      f.payload = rand56();
      if ($urandom_range(0, 9) == 0) tnow = $urandom;
      else tnow += $urandom_range(0, dt_max);
      f.now = tnow;
      send(f);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_timeout_ticks <= value;
      plan_model.timeout = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until the block has taken everything and answered everything
   task automatic wait_drained();
      while (pending_frames.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   task automatic random_phase(input int nitems, input int dt_max);
      int start;
      start = pending_frames.size() + frames_sent;
      while (pending_frames.size() + frames_sent - start < nitems) begin
         if ($urandom_range(0, 4) == 0) send_noise(dt_max);
         else if ($urandom_range(0, 19) == 0)
            // long message to push the length into saturation
            send_message(id_pool[$urandom_range(0, 5)], $urandom_range(31, 34), dt_max);
         else
            send_message(($urandom_range(0, 2) == 0) ? 29'($urandom)
                                                    : id_pool[$urandom_range(0, 5)],
                         $urandom_range(1, 5), dt_max);
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender: one item at a time, random gaps unless the run is in its quiet part
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_frames.size() != 0 && !quiet
                      && $urandom_range(0, 3) == 0) begin
            req_gap <= $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if (pending_frames.size() != 0) begin
            req_valid <= 1'b1;
            req_frame_id <= pending_frames[0].frame_id;
            req_seg_type <= pending_frames[0].seg_type;
            req_seg_index <= pending_frames[0].seg_index;
            req_byte_count <= pending_frames[0].byte_count;
            req_payload <= pending_frames[0].payload;
            req_now <= pending_frames[0].now;
            pending_frames.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: bursts of stalled cycles between free-running stretches
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_cnt <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
         stall_cnt <= $urandom_range(0, 11);
      end
   end

   // monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      frame_type  f;
      result_type got;
      result_type want;
      bit         unsafe;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset && csr_valid && csr_ready) table_model.timeout = csr_timeout_ticks;
      if (!reset && req_valid && !req_stall) begin
         f.frame_id = req_frame_id;
         f.seg_type = csr_pkg::seg_type_type'(req_seg_type);
         f.seg_index = req_seg_index;
         f.byte_count = req_byte_count;
         f.payload = req_payload;
         f.now = req_now;
         apply_frame(table_model, f, expected_results, unsafe);
         frames_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = csr_pkg::status_type'(rsp_status);
         got.msg_id = rsp_msg_id;
         got.chunk = rsp_chunk;
         got.chunk_bytes = rsp_chunk_bytes;
         got.last = rsp_last;
         if (got.status == csr_pkg::ST_DATA) chunks_seen++;
         else status_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item status=%0d id=%h", $realtime,
                        got.status, got.msg_id);
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.msg_id !== want.msg_id
                || got.chunk !== want.chunk || got.chunk_bytes !== want.chunk_bytes
                || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch exp st=%0d id=%h data=%h n=%0d last=%0b",
                            " got st=%0d id=%h data=%h n=%0d last=%0b"},
                           $realtime, want.status, want.msg_id, want.chunk,
                           want.chunk_bytes, want.last,
                           got.status, got.msg_id, got.chunk, got.chunk_bytes,
                           got.last);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus sequencing
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_id = '0;
      req_seg_type = '0;
      req_seg_index = '0;
      req_byte_count = '0;
      req_payload = '0;
      req_now = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_timeout_ticks = '0;
      quiet = 1'b0;
      req_fire = 1'b0;
      req_gap = 0;
      stall_cnt = 0;
      mismatches = 0;
      idle_cycles = 0;
      frames_sent = 0;
      chunks_seen = 0;
      status_seen = 0;
      tnow = 32'd100;
      for (int b = 0; b < NBUF; b++) begin
         table_model.ids[b] = '0;
         table_model.lens[b] = 0;
         table_model.starts[b] = '0;
         for (int k = 0; k < CAP; k++) begin
            table_model.bytes[b][k] = '0;
            table_model.written[b][k] = 0;
         end
      end
      table_model.timeout = csr_pkg::TimeoutReset;
      plan_model = table_model;
      for (int i = 0; i < 6; i++) id_pool[i] = 29'($urandom);
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset timeout, field extremes and every segment case
      write_timeout(csr_pkg::TimeoutReset);
      mk_send('1, csr_pkg::SEG_SINGLE, '1, '1, '1, '1);         // single frame ignored
      mk_send('1, csr_pkg::SEG_BEGIN, '1, '1, '1, tnow);         // all-ones begin
      mk_send('1, csr_pkg::SEG_MIDDLE, 6'd1, '0, 56'h0, tnow);
      mk_send('1, csr_pkg::SEG_MIDDLE, 6'd63, '0, 56'h0, tnow);  // index out of range
      mk_send('1, csr_pkg::SEG_END, 6'd2, 3'd7, 56'h0123456789abcd, tnow);
      mk_send('0, csr_pkg::SEG_BEGIN, '0, '0, 56'h0, tnow);
      mk_send('0, csr_pkg::SEG_END, 6'd1, 3'd0, '1, tnow);       // end with no bytes
      mk_send(29'h155, csr_pkg::SEG_END, 6'd1, 3'd3, '1, tnow);  // no matching message
      mk_send(29'h155, csr_pkg::SEG_MIDDLE, 6'd1, 3'd3, '1, tnow);
      for (int i = 0; i < 5; i++)                               // fifth begin finds no buffer
         mk_send(29'(i + 1), csr_pkg::SEG_BEGIN, '0, '0, rand56(), tnow);
      mk_send(29'd2, csr_pkg::SEG_BEGIN, '0, '0, rand56(), tnow); // restart reuses its buffer
      mk_send(29'd2, csr_pkg::SEG_END, 6'd1, 3'd4, rand56(), tnow);
      tnow += 32'd20001;                                        // sweep frees the rest
      mk_send(29'd1, csr_pkg::SEG_END, 6'd1, 3'd1, rand56(), tnow);
      mk_send(29'd3, csr_pkg::SEG_BEGIN, '0, '0, rand56(), tnow);
      tnow += 32'd20000;                                        // exactly at the limit: kept
      mk_send(29'd3, csr_pkg::SEG_END, 6'd1, 3'd2, rand56(), tnow);
      wait_drained();                                           // sender holds back here
      random_phase(60, 400);
      wait_drained();

      write_timeout(32'd0);
      random_phase(40, 1);
      wait_drained();
      write_timeout(32'hffff_ffff);
      random_phase(50, 100000);
      wait_drained();
      write_timeout(32'd300);
      random_phase(50, 150);
      wait_drained();
      write_timeout(csr_pkg::TimeoutReset);
      quiet = 1'b1;
      random_phase(40, 2000);
      wait_drained();

      $display("covered %0d frames across 5 timeout settings incl. 0 and max", frames_sent);
      $display("checked %0d data chunks and %0d status items, %0d mismatches",
               chunks_seen, status_seen, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
